// ----- rtl/pwk_pkg.sv -----
// Shared widths, constants, types and helper functions of the page table walker.
package pwk_pkg;

  localparam int unsigned PA_W              = 52;
  localparam int unsigned VA_W              = 48;
  localparam int unsigned ENTRY_W           = 64;
  localparam int unsigned VIDX_W            = 9;
  localparam int unsigned ENTRIES_PER_TABLE = 512;
  localparam int unsigned CFG_IDX_W         = 2;

  // Bit positions inside a table entry.
  localparam int unsigned PRESENT_BIT = 0;
  localparam int unsigned LARGE_BIT   = 7;

  // Mask that keeps the frame number of an entry, bits 51:12.
  localparam logic [ENTRY_W-1:0] NEXT_MASK = 64'h000F_FFFF_FFFF_F000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_TABLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_BASE = 2'd1;

  // Request kinds.
  localparam logic REQ_WRITE     = 1'b0;
  localparam logic REQ_TRANSLATE = 1'b1;

  // Walk levels.
  typedef logic [1:0] level_t;
  localparam level_t LVL_TOP  = 2'd0;
  localparam level_t LVL_MID  = 2'd1;
  localparam level_t LVL_DIR  = 2'd2;
  localparam level_t LVL_LEAF = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } walk_state_t;

  // Result of one item before it moves to the output register.
  typedef struct packed {
    logic [PA_W-1:0] phys_address;
    logic            found;
    logic            out_of_window;
  } result_t;

  // Table index that a virtual address selects at a given level.
  function automatic logic [VIDX_W-1:0] vidx(input logic [VA_W-1:0] va, input level_t lvl);
    logic [VIDX_W-1:0] k;
    unique case (lvl)
      LVL_TOP: k = va[47:39];
      LVL_MID: k = va[38:30];
      LVL_DIR: k = va[29:21];
      default: k = va[20:12];
    endcase
    return k;
  endfunction

  // Physical byte address of entry k of the table whose frame sits in base.
  function automatic logic [PA_W-1:0] entry_addr(input logic [PA_W-1:0] base,
                                                  input logic [VIDX_W-1:0] k);
    return {base[PA_W-1:12], k, 3'b000};
  endfunction

endpackage

// ----- rtl/pwk_if.sv -----
// Valid/ready channel interfaces for requests, results and configuration writes.
interface pwk_req_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [pwk_pkg::PA_W-1:0]      address;
  logic [pwk_pkg::ENTRY_W-1:0]   entry_data;

  modport source (output valid, req_type, address, entry_data, input ready);
  modport sink   (input valid, req_type, address, entry_data, output ready);
endinterface

interface pwk_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [pwk_pkg::PA_W-1:0]      phys_address;
  logic                          found;
  logic                          out_of_window;

  modport source (output valid, phys_address, found, out_of_window, input ready);
  modport sink   (input valid, phys_address, found, out_of_window, output ready);
endinterface

interface pwk_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pwk_pkg::CFG_IDX_W-1:0] index;
  logic [pwk_pkg::PA_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/pwk_ram.sv -----
// Generic single-port RAM with a registered read.
module pwk_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write when enabled; the read data is registered every cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/pwk_window.sv -----
// Maps a physical byte address onto the table memory window and its entry index.
module pwk_window #(
  parameter int unsigned TABLE_FRAMES = 16
) (
  input  logic [pwk_pkg::PA_W-1:0]                                          phys,
  input  logic [pwk_pkg::PA_W-1:0]                                          base,
  output logic                                                              hit,
  output logic [$clog2(TABLE_FRAMES*pwk_pkg::ENTRIES_PER_TABLE)-1:0]        idx
);
  import pwk_pkg::*;

  localparam int unsigned MEM_DEPTH = TABLE_FRAMES * ENTRIES_PER_TABLE;
  localparam int unsigned IDX_W     = $clog2(MEM_DEPTH);
  localparam logic [PA_W-1:0] WINDOW_BYTES = PA_W'(MEM_DEPTH * 8);

  logic [PA_W:0] diff;

  // A borrow means the address lies below the window base.
  always_comb begin
    diff = {1'b0, phys} - {1'b0, base};
    hit  = !diff[PA_W] && (diff[PA_W-1:0] < WINDOW_BYTES);
    idx  = diff[IDX_W+2:3];
  end

endmodule

// ----- rtl/four_level_page_walker_top.sv -----
// Top level of the four-level page table walker with its table memory.
//
// Four-level page table walker over a local table memory of TABLE_FRAMES 4 KiB
// frames starting at physical address window_base. A write item stores one
// 64-bit entry if its address lies inside the window. A translate item reads
// one entry per level through the single table memory port (up to four reads,
// the next entry address being formed and window-checked in the cycle the
// previous entry returns), and its result then goes to the output register; a
// walk that stops on an absent entry, a large page or an address outside the
// window reads fewer levels. One item is worked on at a time, and the next item
// is accepted only after the previous result is loaded into the output
// register, while that result may still wait there. The table memory is not
// cleared after reset; every entry must be written before a walk reads it, and
// the block itself does not enforce this.
module four_level_page_walker_top #(
  parameter int unsigned TABLE_FRAMES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  pwk_cfg_if.sink   cfg_wr,
  pwk_req_if.sink   in_req,
  pwk_rsp_if.source out_rsp
);
  import pwk_pkg::*;

  localparam int unsigned MEM_DEPTH = TABLE_FRAMES * ENTRIES_PER_TABLE;
  localparam int unsigned IDX_W     = $clog2(MEM_DEPTH);

  walk_state_t       state_r, state_nxt;
  level_t            lvl_r, lvl_nxt;
  logic [VA_W-1:0]   vaddr_r, vaddr_nxt;
  result_t           res_r, res_nxt;
  result_t           out_r;
  logic              out_valid_r;
  logic [PA_W-1:0]   root_r;
  logic [PA_W-1:0]   base_r;

  logic              in_fire;
  logic              out_free;
  logic [PA_W-1:0]   probe;
  logic              probe_inside;
  logic [IDX_W-1:0]  probe_idx;
  logic              ram_we;
  logic [ENTRY_W-1:0] entry;
  logic [PA_W-1:0]   entry_frame;
  logic              walk_end;
  logic              large_page;

  assign in_req.ready = (state_r == S_IDLE);
  assign in_fire      = in_req.valid && in_req.ready;
  assign out_free     = !out_valid_r || out_rsp.ready;
  assign cfg_wr.ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= '0;
      base_r <= '0;
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      unique case (cfg_wr.index)
        REG_ROOT_TABLE:  root_r <= cfg_wr.data;
        REG_WINDOW_BASE: base_r <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // Window check of the one address that goes to the table memory this cycle.
  pwk_window #(
    .TABLE_FRAMES(TABLE_FRAMES)
  ) u_window (
    .phys   (probe),
    .base   (base_r),
    .hit    (probe_inside),
    .idx    (probe_idx)
  );

  pwk_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MEM_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (probe_idx),
    .wdata (in_req.entry_data),
    .rdata (entry)
  );

  // Decode of the entry returned by the previous read.
  always_comb begin
    entry_frame = entry[PA_W-1:0] & NEXT_MASK[PA_W-1:0];
    large_page  = (lvl_r == LVL_DIR) && entry[LARGE_BIT];
    walk_end    = !entry[PRESENT_BIT] || large_page || (lvl_r == LVL_LEAF);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_req.req_type == REQ_TRANSLATE && probe_inside) begin
            state_nxt = S_WALK;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_WALK: begin
        if (walk_end || !probe_inside) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memory access, walk level and result.
  always_comb begin
    probe     = in_req.address;
    ram_we    = 1'b0;
    lvl_nxt   = lvl_r;
    vaddr_nxt = vaddr_r;
    res_nxt   = res_r;
    unique case (state_r)
      S_IDLE: begin
        lvl_nxt   = LVL_TOP;
        vaddr_nxt = in_req.address[VA_W-1:0];
        if (in_req.req_type == REQ_TRANSLATE) begin
          probe = entry_addr(root_r, vidx(in_req.address[VA_W-1:0], LVL_TOP));
        end
        ram_we  = in_fire && (in_req.req_type == REQ_WRITE) && probe_inside;
        res_nxt = '{phys_address: '0, found: 1'b0, out_of_window: !probe_inside};
      end
      S_WALK: begin
        probe = entry_addr(entry_frame, vidx(vaddr_r, lvl_r + 2'd1));
        if (!entry[PRESENT_BIT]) begin
          res_nxt = '{phys_address: '0, found: 1'b0, out_of_window: 1'b0};
        end else if (large_page) begin
          res_nxt = '{phys_address: entry_frame + {{(PA_W-21){1'b0}}, vaddr_r[20:0]},
                      found: 1'b1, out_of_window: 1'b0};
        end else if (lvl_r == LVL_LEAF) begin
          res_nxt = '{phys_address: entry_frame + {{(PA_W-12){1'b0}}, vaddr_r[11:0]},
                      found: 1'b1, out_of_window: 1'b0};
        end else begin
          lvl_nxt = lvl_r + 2'd1;
          res_nxt = '{phys_address: '0, found: 1'b0, out_of_window: !probe_inside};
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  // Walk control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Walk payload registers.
  always_ff @(posedge clk) begin
    if (state_r != S_DONE) begin
      lvl_r   <= lvl_nxt;
      vaddr_r <= vaddr_nxt;
      res_r   <= res_nxt;
    end
  end

  // Output register that parts the walker from the result channel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_r <= res_r;
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.phys_address  = out_r.phys_address;
  assign out_rsp.found         = out_r.found;
  assign out_rsp.out_of_window = out_r.out_of_window;

  // The table memory is only written when a write item is accepted.
  a_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (in_fire && state_r == S_IDLE))
    else $error("table memory written outside an accepted write item");

  // A result is never both found and out of window.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.found && out_r.out_of_window))
    else $error("result flags found and out_of_window both set");

  // A result that was not found carries a zero address.
  a_zero_when_missing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.found) |-> (out_r.phys_address == '0))
    else $error("non-zero address on a failed result");

  // Each further cycle in the walk moves down exactly one level.
  a_level_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && $past(state_r) == S_WALK) |-> (lvl_r == $past(lvl_r) + 2'd1))
    else $error("walk level did not advance by one");

endmodule

// ----- verif/tb_four_level_page_walker_top.sv -----
// Self-checking testbench for the four-level page table walker top level.
`timescale 1ns / 1ps

module tb_four_level_page_walker_top;
  import pwk_pkg::*;

  localparam int unsigned TABLE_FRAMES = 16;
  localparam int          MEM_DEPTH    = TABLE_FRAMES * ENTRIES_PER_TABLE;
  localparam logic [63:0] WINDOW_BYTES = 64'(MEM_DEPTH * 8);
  localparam logic [63:0] PTE_P        = 64'h1;
  localparam logic [63:0] PTE_L        = 64'h80;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam logic [PA_W-1:0] MASK_ALL52 = '1;

  // Mirror of the walker: its table memory, registers and the results still owed.
  class walk_scoreboard;
    logic [63:0]     tbl [MEM_DEPTH];
    bit              written [MEM_DEPTH];
    logic [PA_W-1:0] root;
    logic [PA_W-1:0] wbase;
    result_t         owed[$];
    int              errors;

    function new();
      root   = '0;
      wbase  = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [PA_W-1:0] val);
      case (idx)
        REG_ROOT_TABLE:  root  = val;
        REG_WINDOW_BASE: wbase = val;
        default: ;
      endcase
    endfunction

    // Byte offsets are taken from the window base, so an unaligned base shifts the mapping.
    function bit in_window(input logic [PA_W-1:0] pa, output int idx);
      logic [63:0] off;
      idx = 0;
      if (pa < wbase) return 1'b0;
      off = 64'(pa) - 64'(wbase);
      if (off >= WINDOW_BYTES) return 1'b0;
      idx = int'(off >> 3);
      return 1'b1;
    endfunction

    // Walks up to four levels; returns the index of an unwritten entry it would read, or -1.
    function int walk(input logic [PA_W-1:0] va, output result_t res);
      logic [63:0]       base;
      logic [63:0]       ea;
      logic [63:0]       entry;
      logic [63:0]       phys;
      logic [VIDX_W-1:0] k;
      int                idx;
      res  = '0;
      base = 64'(root) & NEXT_MASK;
      for (int l = 0; l < 4; l++) begin
        k  = va[39 - 9*l +: 9];
        ea = base + 64'({k, 3'b000});
        if (!in_window(ea[PA_W-1:0], idx)) begin
          res.out_of_window = 1'b1;
          return -1;
        end
        if (!written[idx]) return idx;
        entry = tbl[idx];
        if (!entry[PRESENT_BIT]) return -1;
        // A large page ends the walk only at the directory level.
        if (l == int'(LVL_DIR) && entry[LARGE_BIT]) begin
          phys             = (entry & NEXT_MASK) + 64'(va[20:0]);
          res.phys_address = phys[PA_W-1:0];
          res.found        = 1'b1;
          return -1;
        end
        base = entry & NEXT_MASK;
      end
      phys             = base + 64'(va[11:0]);
      res.phys_address = phys[PA_W-1:0];
      res.found        = 1'b1;
      return -1;
    endfunction

    function void note_item(logic kind, logic [PA_W-1:0] addr, logic [ENTRY_W-1:0] data);
      result_t r;
      int      idx;
      int      hole;
      r = '0;
      if (kind == REQ_WRITE) begin
        if (in_window(addr, idx)) begin
          tbl[idx]     = data;
          written[idx] = 1'b1;
        end else begin
          r.out_of_window = 1'b1;
        end
      end else begin
        hole = walk(addr, r);
        if (hole >= 0) begin
          $error("translate of %h would read unwritten entry %0d", addr, hole);
          errors++;
        end
      end
      owed.push_back(r);
    endfunction

    function void check_result(logic [PA_W-1:0] pa, logic found, logic oow);
      result_t e;
      if (owed.size() == 0) begin
        $error("unexpected result: phys_address %h found %b out_of_window %b", pa, found, oow);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (pa !== e.phys_address) begin
        $error("phys_address: expected %h, actual %h", e.phys_address, pa);
        errors++;
      end
      if (found !== e.found) begin
        $error("found: expected %b, actual %b", e.found, found);
        errors++;
      end
      if (oow !== e.out_of_window) begin
        $error("out_of_window: expected %b, actual %b", e.out_of_window, oow);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  pwk_cfg_if cfg_ch();
  pwk_req_if req_ch();
  pwk_rsp_if rsp_ch();

  walk_scoreboard  sb = new();
  int              sent = 0;
  int              cycle_count = 0;
  int              hold_left = 0;
  bit              quiet = 1'b0;
  logic [PA_W-1:0] last_va = '0;

  four_level_page_walker_top #(.TABLE_FRAMES(TABLE_FRAMES)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_wr  (cfg_ch),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Handshake monitors: registers, accepted items and accepted results.
  always @(posedge clk) begin
    if (rst_n && cfg_ch.valid && cfg_ch.ready) sb.set_reg(cfg_ch.index, cfg_ch.data);
    if (rst_n && req_ch.valid && req_ch.ready)
      sb.note_item(req_ch.req_type, req_ch.address, req_ch.entry_data);
    if (rst_n && rsp_ch.valid && rsp_ch.ready)
      sb.check_result(rsp_ch.phys_address, rsp_ch.found, rsp_ch.out_of_window);
  end

  // Result receiver: random stalls, a quiet stretch and one long hold-off.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else if (quiet) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= 17);
      end
    end
  end

  function automatic logic [PA_W-1:0] rand52();
    logic [63:0] t;
    t = {$urandom, $urandom};
    return t[PA_W-1:0];
  endfunction

  // Random table entry, mostly present and pointing at a frame inside the window.
  function automatic logic [63:0] make_entry();
    logic [63:0] e;
    logic [39:0] frame;
    int          r;
    e     = {$urandom, $urandom};
    r     = $urandom_range(0, 99);
    frame = sb.wbase[51:12] + 40'($urandom_range(0, TABLE_FRAMES - 1));
    if (r >= 90) frame = 40'(rand52() >> 12);
    else if (r >= 80) frame = sb.wbase[51:12] + 40'(TABLE_FRAMES);
    e[51:12]      = frame;
    e[PRESENT_BIT] = ($urandom_range(0, 99) < 90);
    e[LARGE_BIT]   = ($urandom_range(0, 99) < 25);
    return e;
  endfunction

  // Write address for stray writes: in the window, anywhere, or on its edges.
  function automatic logic [PA_W-1:0] stray_addr();
    logic [63:0] a;
    int          r;
    r = $urandom_range(0, 9);
    if (r < 6) a = 64'(sb.wbase) + 64'($urandom_range(0, int'(WINDOW_BYTES) - 1));
    else if (r < 8) a = 64'(rand52());
    else begin
      case ($urandom_range(0, 2))
        0:       a = 64'(sb.wbase) - 64'd1;
        1:       a = 64'(sb.wbase) + WINDOW_BYTES - 64'd1;
        default: a = 64'(sb.wbase) + WINDOW_BYTES;
      endcase
    end
    return a[PA_W-1:0];
  endfunction

  // Offers one item, with random gaps before it; returns at the falling edge after acceptance.
  task automatic send_req(input logic kind, input logic [PA_W-1:0] addr,
                          input logic [ENTRY_W-1:0] data);
    while (!quiet && $urandom_range(0, 99) < 17) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.address    <= addr;
    req_ch.entry_data <= data;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_config(input logic [PA_W-1:0] root, input logic [PA_W-1:0] base);
    write_reg(REG_WINDOW_BASE, base);
    write_reg(REG_ROOT_TABLE, root);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Stops offering items and waits until every owed result has come back.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (sb.owed.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // Fills in any table entry the walk would read unwritten, then translates.
  task automatic walk_to(input logic [PA_W-1:0] va);
    result_t     r;
    int          hole;
    logic [63:0] a;
    hole = sb.walk(va, r);
    while (hole >= 0) begin
      a = 64'(sb.wbase) + 64'(hole) * 64'd8;
      if (a + 64'd7 <= 64'(MASK_ALL52)) a = a + 64'($urandom_range(0, 7));
      send_req(REQ_WRITE, a[PA_W-1:0], make_entry());
      hole = sb.walk(va, r);
    end
    send_req(REQ_TRANSLATE, va, {$urandom, $urandom});
  endtask

  task automatic run_random(input int count);
    int              stop;
    int              r;
    logic [PA_W-1:0] va;
    stop = sent + count;
    while (sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        send_req(REQ_WRITE, stray_addr(), (r < 6) ? make_entry() : {$urandom, $urandom});
      end else begin
        // Half the walks reuse the upper levels of the previous one.
        if ($urandom_range(0, 1)) begin
          va = rand52();
        end else begin
          va = last_va;
          if ($urandom_range(0, 1)) va[20:0] = 21'($urandom);
          else va[29:0] = 30'($urandom);
        end
        last_va = va;
        walk_to(va);
      end
    end
  endtask

  // Hand-built tables with the window and root at address zero.
  task automatic directed();
    // A plain four-level chain to a 4 KiB page.
    send_req(REQ_WRITE, 52'h0_0000, 64'h1000 | PTE_P);
    send_req(REQ_WRITE, 52'h0_1000, 64'h2000 | PTE_P);
    send_req(REQ_WRITE, 52'h0_2000, 64'h3000 | PTE_P);
    send_req(REQ_WRITE, 52'h0_3000, 64'hABCD_E000 | PTE_P);
    send_req(REQ_TRANSLATE, 52'h0_0FFF, '0);
    // 2 MiB page at the directory level.
    send_req(REQ_WRITE, 52'h0_2008, 64'h3FE0_0000 | PTE_P | PTE_L);
    send_req(REQ_TRANSLATE, (52'd1 << 21) | 52'h1_2345, '1);
    // 2 MiB page at the top of the address space: the sum wraps.
    send_req(REQ_WRITE, 52'h0_2010, 64'h000F_FFFF_FFFF_F000 | PTE_P | PTE_L);
    send_req(REQ_TRANSLATE, (52'd2 << 21) | 52'h1F_FFFF, '0);
    // Absent directory entry with every other bit set.
    send_req(REQ_WRITE, 52'h0_2018, 64'hFFFF_FFFF_FFFF_FFFE);
    send_req(REQ_TRANSLATE, 52'd3 << 21, '0);
    // Large bit at the second level is ignored: the entry is a table pointer.
    send_req(REQ_WRITE, 52'h0_1008, 64'h4000 | PTE_P | PTE_L);
    send_req(REQ_WRITE, 52'h0_4000, 64'h5000 | PTE_P);
    send_req(REQ_WRITE, 52'h0_5000, 64'h0000_1234_5678_9000 | PTE_P);
    send_req(REQ_TRANSLATE, (52'd1 << 30) | 52'hABC, '0);
    // A pointer to a frame past the window stops the walk.
    send_req(REQ_WRITE, 52'h0_0008, 64'h10_0000 | PTE_P);
    send_req(REQ_TRANSLATE, 52'd1 << 39, '0);
    // All-ones entry under an all-ones virtual address.
    send_req(REQ_WRITE, 52'h0_0FF8, '1);
    send_req(REQ_TRANSLATE, '1, '1);
    // Writes just past the window, at the top of the space, and on the last entry.
    send_req(REQ_WRITE, 52'(WINDOW_BYTES), 64'h1);
    send_req(REQ_WRITE, '1, '1);
    send_req(REQ_WRITE, 52'(WINDOW_BYTES) - 52'd1, '0);
  endtask

  // Main sequence: reset, directed items, then phases of random walks under varied registers.
  initial begin
    logic [PA_W-1:0] base;
    logic [PA_W-1:0] root;
    rst_n             = 1'b0;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = REQ_WRITE;
    req_ch.address    = '0;
    req_ch.entry_data = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_ROOT_TABLE;
    cfg_ch.data       = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_config('0, '0);
    directed();
    run_random(300);

    for (int p = 1; p < 8; p++) begin
      drain();
      case (p)
        1: begin
          base = '1;
          root = '1;
        end
        2: begin
          base = 52'hF_FFFF_FFFF_0000;
          root = 52'hF_FFFF_FFFF_3ABC;
        end
        3: begin
          base = (rand52() & 52'hF_FFFF_FFFF_F000) + 52'($urandom_range(1, 4095));
          root = base + (52'd2 << 12);
        end
        5: begin
          base = rand52() & 52'hF_FFFF_FFFF_F000;
          root = rand52();
        end
        default: begin
          base = rand52() & 52'hF_FFFF_FFFF_F000;
          root = base + (52'($urandom_range(0, TABLE_FRAMES - 1)) << 12)
                 + 52'($urandom_range(0, 4095));
        end
      endcase
      set_config(root, base);
      quiet = (p == 3);
      // Long hold-off on results while items keep coming, so the input stalls.
      if (p == 4) hold_left = 300;
      run_random((p == 1) ? 80 : (p == 5) ? 120 : 270);
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- four_level_page_walker_top.f -----
rtl/pwk_pkg.sv
rtl/pwk_if.sv
rtl/pwk_ram.sv
rtl/pwk_window.sv
rtl/four_level_page_walker_top.sv
verif/tb_four_level_page_walker_top.sv
